// ===== sv/lfu_pkg.sv =====
package lfu_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int COUNT_BITS    = 16;
    localparam int CAP_W         = 5;
    localparam int KEY_W         = 16;
    localparam int VAL_W         = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Datapath commands from the controller
    typedef struct packed {
        logic scan_clear;   // reset scan trackers at request start
        logic scan_step;    // examine one entry
        logic use_found;    // bump count, write value on put, touch recency
        logic evict;        // drop the chosen victim
        logic insert;       // write new entry into first free slot
        logic rank_step;    // apply pending rank adjust to one entry
    } lfu_cmd_t;

    // Status back to the controller
    typedef struct packed {
        logic scan_last;    // scan index is at the last entry
        logic found;        // key match seen
        logic victim_ok;    // a victim was chosen
        logic full;         // occupancy at or above capacity
        logic cap_zero;     // effective capacity is zero
    } lfu_stat_t;

endpackage

// ===== sv/lfu_if.sv =====
interface lfu_req_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [lfu_pkg::KEY_W-1:0]    key;
    logic signed [lfu_pkg::VAL_W-1:0] value;

    modport source (output valid, command, key, value, input ready);
    modport sink   (input valid, command, key, value, output ready);
endinterface

interface lfu_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [lfu_pkg::VAL_W-1:0] read_value;
    logic                         evicted;
    logic [lfu_pkg::KEY_W-1:0]    evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ===== sv/lfu_datapath.sv =====
module lfu_datapath #(
    parameter int TABLE_ENTRIES = lfu_pkg::TABLE_ENTRIES,
    parameter int COUNT_BITS    = lfu_pkg::COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]      cfg_data,
    input  logic                           load,
    input  logic                           command,
    input  logic [lfu_pkg::KEY_W-1:0]      key,
    input  logic [lfu_pkg::VAL_W-1:0]      value,
    input  lfu_pkg::lfu_cmd_t              cmd,
    output lfu_pkg::lfu_stat_t             stat,
    output logic [lfu_pkg::VAL_W-1:0]      found_value,
    output logic [lfu_pkg::KEY_W-1:0]      victim_key
);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);
    localparam int RANK_W = IDX_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Rank adjust kinds applied during the rank sweep
    typedef enum logic [1:0] {ADJ_TOUCH, ADJ_DROP, ADJ_INSERT} adj_t;

    logic [lfu_pkg::CAP_W-1:0]  cap_reg;
    logic [TABLE_ENTRIES-1:0]   valid_reg;
    logic [lfu_pkg::KEY_W-1:0]  key_mem   [TABLE_ENTRIES];
    logic [lfu_pkg::VAL_W-1:0]  val_mem   [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]      cnt_mem   [TABLE_ENTRIES];
    logic [RANK_W-1:0]          rank_mem  [TABLE_ENTRIES];
    logic [OCC_W-1:0]           occ_reg;

    logic [lfu_pkg::KEY_W-1:0]  key_reg;
    logic [lfu_pkg::VAL_W-1:0]  val_reg;
    logic                       cmd_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic                       found_reg;
    logic [IDX_W-1:0]           found_idx_reg;
    logic                       vic_ok_reg;
    logic [IDX_W-1:0]           vic_idx_reg;
    logic                       free_ok_reg;
    logic [IDX_W-1:0]           free_idx_reg;
    adj_t                       adj_reg;
    logic [RANK_W-1:0]          adj_rank_reg;
    logic [IDX_W-1:0]           adj_idx_reg;

    logic [OCC_W-1:0]           cap_eff;
    logic                       better;
    logic                       evicted_slot;
    logic [IDX_W-1:0]           ins_idx;

    // Effective capacity clamped to table size
    always_comb
    begin
        if (32'(cap_reg) > TABLE_ENTRIES)
            cap_eff = OCC_W'(TABLE_ENTRIES);
        else
            cap_eff = OCC_W'(cap_reg);
    end

    // Victim compare for scanned entry
    always_comb
    begin
        better = !vic_ok_reg
              || (cnt_mem[idx_reg] < cnt_mem[vic_idx_reg])
              || (cnt_mem[idx_reg] == cnt_mem[vic_idx_reg]
                  && rank_mem[idx_reg] > rank_mem[vic_idx_reg]);
    end

    // Victim slot was emptied by this request
    assign evicted_slot = vic_ok_reg && !valid_reg[vic_idx_reg];

    // After an eviction the victim slot is the lowest free one unless an earlier slot was free
    assign ins_idx = (free_ok_reg && !(evicted_slot && vic_idx_reg < free_idx_reg))
                   ? free_idx_reg : vic_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= lfu_pkg::CAP_RESET;
            valid_reg   <= '0;
            occ_reg     <= '0;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            vic_ok_reg  <= 1'b0;
            free_ok_reg <= 1'b0;
            adj_reg     <= ADJ_TOUCH;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;
            if (load)
            begin
                key_reg <= key;
                val_reg <= value;
                cmd_reg <= command;
            end
            // One entry per cycle: key match, free slot, victim
            if (cmd.scan_clear)
            begin
                idx_reg     <= '0;
                found_reg   <= 1'b0;
                vic_ok_reg  <= 1'b0;
                free_ok_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (valid_reg[idx_reg])
                begin
                    if (!found_reg && key_mem[idx_reg] == key_reg)
                    begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= idx_reg;
                    end
                    if (better)
                    begin
                        vic_ok_reg  <= 1'b1;
                        vic_idx_reg <= idx_reg;
                    end
                end
                else if (!free_ok_reg)
                begin
                    free_ok_reg  <= 1'b1;
                    free_idx_reg <= idx_reg;
                end
                if (idx_reg != LAST_IDX)
                    idx_reg <= idx_reg + 1'b1;
                else
                    idx_reg <= '0;
            end
            else if (cmd.rank_step)
            begin
                if (valid_reg[idx_reg] && idx_reg != adj_idx_reg)
                begin
                    case (adj_reg)
                        ADJ_TOUCH:
                            if (rank_mem[idx_reg] < adj_rank_reg)
                                rank_mem[idx_reg] <= rank_mem[idx_reg] + 1'b1;
                        ADJ_DROP:
                            if (rank_mem[idx_reg] > adj_rank_reg)
                                rank_mem[idx_reg] <= rank_mem[idx_reg] - 1'b1;
                        ADJ_INSERT:
                            rank_mem[idx_reg] <= rank_mem[idx_reg] + 1'b1;
                        default: ;
                    endcase
                end
                if (idx_reg != LAST_IDX)
                    idx_reg <= idx_reg + 1'b1;
                else
                    idx_reg <= '0;
            end
            // Hit: count, value, recency setup
            if (cmd.use_found)
            begin
                if (cnt_mem[found_idx_reg] != COUNT_MAX)
                    cnt_mem[found_idx_reg] <= cnt_mem[found_idx_reg] + 1'b1;
                if (cmd_reg == lfu_pkg::CMD_PUT)
                    val_mem[found_idx_reg] <= val_reg;
                adj_reg      <= ADJ_TOUCH;
                adj_rank_reg <= rank_mem[found_idx_reg];
                adj_idx_reg  <= found_idx_reg;
                rank_mem[found_idx_reg] <= '0;
            end
            // Eviction: clear slot, then close rank gap
            if (cmd.evict)
            begin
                valid_reg[vic_idx_reg] <= 1'b0;
                occ_reg      <= occ_reg - 1'b1;
                adj_reg      <= ADJ_DROP;
                adj_rank_reg <= rank_mem[vic_idx_reg];
                adj_idx_reg  <= vic_idx_reg;
            end
            // Insert: write entry, age everyone else
            if (cmd.insert)
            begin
                valid_reg[ins_idx] <= 1'b1;
                key_mem[ins_idx]   <= key_reg;
                val_mem[ins_idx]   <= val_reg;
                cnt_mem[ins_idx]   <= COUNT_BITS'(1);
                rank_mem[ins_idx]  <= '0;
                occ_reg      <= occ_reg + 1'b1;
                adj_reg      <= ADJ_INSERT;
                adj_idx_reg  <= ins_idx;
            end
        end
    end

    // Status to the controller
    always_comb
    begin
        stat.scan_last = (idx_reg == LAST_IDX);
        stat.found     = found_reg;
        stat.victim_ok = vic_ok_reg;
        stat.full      = (occ_reg >= cap_eff);
        stat.cap_zero  = (cap_eff == '0);
    end

    assign found_value = val_mem[found_idx_reg];
    assign victim_key  = key_mem[vic_idx_reg];

`ifndef SYNTHESIS
    // Occupancy never exceeds the table size
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(occ_reg) <= TABLE_ENTRIES)
        else $error("occupancy above table size");
    // Eviction and insert never happen in the same cycle
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.evict && cmd.insert))
        else $error("evict and insert together");
    // Eviction only with a chosen victim
    a_vic: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.evict |-> vic_ok_reg && valid_reg[vic_idx_reg])
        else $error("evict without victim");
`endif

endmodule

// ===== sv/lfu_ctrl.sv =====
module lfu_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic                      req_command,
    output logic                      load,
    output lfu_pkg::lfu_cmd_t         cmd,
    input  lfu_pkg::lfu_stat_t        stat,
    input  logic [lfu_pkg::VAL_W-1:0] found_value,
    input  logic [lfu_pkg::KEY_W-1:0] victim_key,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output logic                      rsp_hit,
    output logic [lfu_pkg::VAL_W-1:0] rsp_read_value,
    output logic                      rsp_evicted,
    output logic [lfu_pkg::KEY_W-1:0] rsp_evicted_key
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_EVICT  = 7'b0001000,
        S_RANK   = 7'b0010000,
        S_INSERT = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   cmd_reg;
    logic   ins_after_reg, ins_after_next;
    logic   out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        ins_after_next = ins_after_reg;
        cmd            = '0;
        load           = 1'b0;
        case (state_reg)
            S_IDLE:
                if (req_valid && !out_valid_reg)
                begin
                    load           = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN;
                end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                ins_after_next = 1'b0;
                if (stat.found)
                begin
                    cmd.use_found = 1'b1;
                    state_next    = S_RANK;
                end
                else if (cmd_reg == lfu_pkg::CMD_GET || stat.cap_zero)
                    state_next = S_DONE;
                else if (stat.full && stat.victim_ok)
                    state_next = S_EVICT;
                else
                    state_next = S_INSERT;
            end
            S_EVICT:
            begin
                cmd.evict      = 1'b1;
                ins_after_next = 1'b1;
                state_next     = S_RANK;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_RANK;
            end
            S_RANK:
            begin
                cmd.rank_step = 1'b1;
                if (stat.scan_last)
                begin
                    ins_after_next = 1'b0;
                    state_next = ins_after_reg ? S_INSERT : S_DONE;
                end
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ins_after_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ins_after_reg <= ins_after_next;
            if (load)
                cmd_reg <= req_command;
            // Result register; fields built up during the request
            if (rsp_valid && rsp_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_DECIDE)
            begin
                rsp_hit         <= stat.found;
                rsp_evicted     <= 1'b0;
                rsp_evicted_key <= '0;
                if (cmd_reg == lfu_pkg::CMD_PUT)
                    rsp_read_value <= '0;
                else if (stat.found)
                    rsp_read_value <= found_value;
                else
                    rsp_read_value <= '1;
            end
            if (state_reg == S_EVICT)
            begin
                rsp_evicted     <= 1'b1;
                rsp_evicted_key <= victim_key;
            end
            if (state_reg == S_DONE)
                out_valid_reg <= 1'b1;
        end
    end

    assign req_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp_valid = out_valid_reg;

`ifndef SYNTHESIS
    // A request is loaded only when no result is pending
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !out_valid_reg)
        else $error("load with pending result");
    // Result appears in the cycle after the done state
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> out_valid_reg)
        else $error("result missing after done");
    // Eviction always continues to rank sweep then insert
    a_evict: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVICT |=> state_reg == S_RANK && ins_after_reg)
        else $error("eviction flow broken");
`endif

endmodule

// ===== sv/lfu_cache_table.sv =====
// LFU cache table: fully associative key/value store, least-frequently-used
// replacement with least-recent tiebreak. Requests are handled one at a time:
// a key/victim scan of one entry per cycle over all TABLE_ENTRIES entries, then a
// rank sweep over all entries for any hit, eviction or insert (two sweeps when
// a put evicts). The next request can be accepted in the cycle after the
// result is taken. The user must write capacity only while idle; the block
// does not enforce this.
module lfu_cache_table #(
    parameter int TABLE_ENTRIES = lfu_pkg::TABLE_ENTRIES,
    parameter int COUNT_BITS    = lfu_pkg::COUNT_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_data,
    lfu_req_if.sink                   req,
    lfu_rsp_if.source                 rsp
);
    logic                      load;
    lfu_pkg::lfu_cmd_t         cmd;
    lfu_pkg::lfu_stat_t        stat;
    logic [lfu_pkg::VAL_W-1:0] found_value;
    logic [lfu_pkg::VAL_W-1:0] read_value;
    logic [lfu_pkg::KEY_W-1:0] victim_key;

    lfu_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .load        (load),
        .command     (req.command),
        .key         (req.key),
        .value       (req.value),
        .cmd         (cmd),
        .stat        (stat),
        .found_value (found_value),
        .victim_key  (victim_key)
    );

    lfu_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req.valid),
        .req_ready       (req.ready),
        .req_command     (req.command),
        .load            (load),
        .cmd             (cmd),
        .stat            (stat),
        .found_value     (found_value),
        .victim_key      (victim_key),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_hit         (rsp.hit),
        .rsp_read_value  (read_value),
        .rsp_evicted     (rsp.evicted),
        .rsp_evicted_key (rsp.evicted_key)
    );

    assign rsp.read_value = read_value;

endmodule
